// ===== src/assert_macros.svh =====
// Assertion macros shared by the rational add/subtract RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rasr_pkg.sv =====
// Shared types and constants of the rational add/subtract block.
`timescale 1ns / 1ps

package rasr_pkg;

   // Result field widths and the packed result beat.
   localparam int RES_NUM_W  = 32;
   localparam int RES_DEN_W  = 31;
   localparam int RSP_DATA_W = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;

   // Widest internal value, used to wrap results to their field widths.
   localparam int WIDE_W = 64;
   typedef logic [WIDE_W-1:0] wide_type;

   // Multiplier operand selection.
   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_AD = 2'd0;  // |first_num| * second_den
   localparam mul_sel_type MUL_CB = 2'd1;  // |second_num| * first_den
   localparam mul_sel_type MUL_BD = 2'd2;  // first_den * second_den

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        p1_en;
      logic        num_en;
      logic        norm_en;
      logic        twos_en;
      logic        gcd_en;
      logic        div_start;
      logic        div_den;
      logic        div_step;
      logic        div_wr_num;
      logic        div_wr_den;
      logic        out_load;
   } rasr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic num_zero;
      logic both_even;
      logic u_zero;
      logic div_last;
   } rasr_status_type;

endpackage

// ===== src/rational_add_sub_reduce.sv =====
// Top level of the rational add/subtract unit with gcd reduction.
//
//   Channel  Direction  Beat contents (lowest bits first)
//   req_     in         tdata: first_num, first_den, second_num, second_den; tuser: kind
//   rsp_     out        tdata: result_num, result_den
//
// One beat at a time: three shared-multiplier products, a sign split, stripping of shared
// twos, binary gcd steps, two restoring divisions of 2*OPERAND_WIDTH quotient bits and
// an output load, after which the result beat is presented.
// A zero numerator goes from the sign split straight to the output load.
// Reset is synchronous and clears the controller and the divider step counter.
// A stalled result holds the output register; the next beat runs and waits in its last state.
`timescale 1ns / 1ps

module rational_add_sub_reduce
   import rasr_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // first_num, first_den, second_num, second_den, zero pad
   input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]        req_tdata,
   // kind
   input  logic [0:0]                                  req_tuser,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // result_num, result_den, zero pad
   output logic [RSP_DATA_W-1:0]                       rsp_tdata
);

   localparam int W = OPERAND_WIDTH;

   rasr_cmd_type         cmd;
   rasr_status_type      status;
   logic [W-1:0]         first_num;
   logic [W-1:0]         first_den;
   logic [W-1:0]         second_num;
   logic [W-1:0]         second_den;
   logic [RES_NUM_W-1:0] result_num;
   logic [RES_DEN_W-1:0] result_den;

   // Unpack the request beat.
   assign first_num  = req_tdata[W-1:0];
   assign first_den  = req_tdata[2*W-1:W];
   assign second_num = req_tdata[3*W-1:2*W];
   assign second_den = req_tdata[4*W-1:3*W];

   // Pack the result beat.
   assign rsp_tdata = RSP_DATA_W'({result_den, result_num});

   rasr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rasr_dpath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .kind       (req_tuser[0]),
      .first_num  (first_num),
      .first_den  (first_den),
      .second_num (second_num),
      .second_den (second_den),
      .result_num (result_num),
      .result_den (result_den)
   );

endmodule

// ===== src/rasr_dpath.sv =====
// Datapath: shared multiplier, binary gcd and restoring divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rasr_dpath
   import rasr_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rasr_cmd_type                    cmd,
   output rasr_status_type                 status,
   input  logic                            kind,
   input  logic signed [OPERAND_WIDTH-1:0] first_num,
   input  logic signed [OPERAND_WIDTH-1:0] first_den,
   input  logic signed [OPERAND_WIDTH-1:0] second_num,
   input  logic signed [OPERAND_WIDTH-1:0] second_den,
   output logic        [RES_NUM_W-1:0]     result_num,
   output logic        [RES_DEN_W-1:0]     result_den
);

   localparam int W  = OPERAND_WIDTH;
   localparam int MW = 2 * OPERAND_WIDTH;
   localparam int CW = $clog2(MW);

   // Operand registers.
   logic          sub_ff, sub_in;
   logic          a_neg_ff, a_neg_in;
   logic          c_neg_ff, c_neg_in;
   logic [W-1:0]  a_mag_ff, a_mag_in;
   logic [W-1:0]  c_mag_ff, c_mag_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  d_ff, d_in;

   // Product, sum and reduction registers.
   logic [MW-1:0] prod_ff, prod_in;
   logic [MW-1:0] p1_ff, p1_in;
   logic [MW-1:0] num_ff, num_in;
   logic          neg_ff, neg_in;
   logic [MW-1:0] mag_ff, mag_in;
   logic [MW-1:0] den_ff, den_in;
   logic [MW-1:0] u_ff, u_in;
   logic [MW-1:0] v_ff, v_in;

   // Divider registers.
   logic [MW-1:0] rem_ff, rem_in;
   logic [MW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // Result registers.
   logic [RES_NUM_W-1:0] out_num_ff, out_num_in;
   logic [RES_DEN_W-1:0] out_den_ff, out_den_in;

   // Combinational helpers.
   logic [W-1:0]  mul_x, mul_y;
   logic [MW-1:0] mul_p;
   logic [MW-1:0] num_mag;
   logic [MW:0]   diff_uv;
   logic [MW-1:0] diff_vu;
   logic [MW-1:0] shifted;
   logic [MW:0]   trial;
   logic          fits;
   logic [MW-1:0] quo_step;
   wide_type      num_wide;
   wide_type      den_wide;

   // A denominator that is zero or negative counts as one.
   function automatic logic [OPERAND_WIDTH-1:0] fix_den(
      input logic [OPERAND_WIDTH-1:0] x
   );
      logic bad;
      bad = x[OPERAND_WIDTH-1] || (x == '0);
      return bad ? OPERAND_WIDTH'(1) : x;
   endfunction

   // Shared multiplier input selection.
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_AD: begin
            mul_x = a_mag_ff;
            mul_y = d_ff;
         end
         MUL_CB: begin
            mul_x = c_mag_ff;
            mul_y = b_ff;
         end
         MUL_BD: begin
            mul_x = b_ff;
            mul_y = d_ff;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign mul_p = MW'(mul_x) * MW'(mul_y);

   // Magnitude of the signed numerator.
   assign num_mag = num_ff[MW-1] ? (MW'(0) - num_ff) : num_ff;

   // Binary gcd differences.
   assign diff_uv = {1'b0, u_ff} - {1'b0, v_ff};
   assign diff_vu = v_ff - u_ff;

   // One restoring division step against the odd gcd in v.
   assign shifted  = {rem_ff[MW-2:0], quo_ff[MW-1]};
   assign trial    = {1'b0, shifted} - {1'b0, v_ff};
   assign fits     = !trial[MW];
   assign quo_step = {quo_ff[MW-2:0], fits};

   // Wrap the reduced values to the result field widths.
   always_comb begin
      num_wide = wide_type'(mag_ff);
      if (neg_ff) begin
         num_wide = wide_type'(0) - num_wide;
      end
      den_wide = wide_type'(den_ff);
   end

   // Next-state logic of all datapath registers.
   always_comb begin
      sub_in     = sub_ff;
      a_neg_in   = a_neg_ff;
      c_neg_in   = c_neg_ff;
      a_mag_in   = a_mag_ff;
      c_mag_in   = c_mag_ff;
      b_in       = b_ff;
      d_in       = d_ff;
      prod_in    = prod_ff;
      p1_in      = p1_ff;
      num_in     = num_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      den_in     = den_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      out_num_in = out_num_ff;
      out_den_in = out_den_ff;

      // Capture the operands of an accepted beat.
      if (cmd.load) begin
         sub_in   = kind;
         a_neg_in = first_num[W-1];
         c_neg_in = second_num[W-1];
         a_mag_in = first_num[W-1] ? (W'(0) - $unsigned(first_num)) : $unsigned(first_num);
         c_mag_in = second_num[W-1] ? (W'(0) - $unsigned(second_num))
                                    : $unsigned(second_num);
         b_in     = fix_den($unsigned(first_den));
         d_in     = fix_den($unsigned(second_den));
      end

      if (cmd.mul_en) begin
         prod_in = mul_p;
      end

      // First cross product with its sign applied.
      if (cmd.p1_en) begin
         p1_in = a_neg_ff ? (MW'(0) - prod_ff) : prod_ff;
      end

      // Add or subtract the second cross product.
      if (cmd.num_en) begin
         num_in = (c_neg_ff ^ sub_ff) ? (p1_ff - prod_ff) : (p1_ff + prod_ff);
      end

      // Split sign and magnitude; a zero numerator gives 0/1.
      if (cmd.norm_en) begin
         neg_in = num_ff[MW-1];
         mag_in = num_mag;
         u_in   = num_mag;
         v_in   = prod_ff;
         den_in = (num_ff == '0) ? MW'(1) : prod_ff;
      end

      // Strip common factors of two from both values.
      if (cmd.twos_en) begin
         u_in   = u_ff >> 1;
         v_in   = v_ff >> 1;
         mag_in = mag_ff >> 1;
         den_in = den_ff >> 1;
      end

      // One binary gcd step.
      if (cmd.gcd_en) begin
         if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (!diff_uv[MW]) begin
            u_in = diff_uv[MW-1:0] >> 1;
         end else begin
            v_in = diff_vu >> 1;
         end
      end

      // Divider start takes priority over a step in the same cycle.
      if (cmd.div_start) begin
         quo_in = cmd.div_den ? den_ff : mag_ff;
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         quo_in = quo_step;
         rem_in = fits ? trial[MW-1:0] : shifted;
         cnt_in = cnt_ff + CW'(1);
      end

      if (cmd.div_wr_num) begin
         mag_in = quo_step;
      end
      if (cmd.div_wr_den) begin
         den_in = quo_step;
      end

      if (cmd.out_load) begin
         out_num_in = num_wide[RES_NUM_W-1:0];
         out_den_in = den_wide[RES_DEN_W-1:0];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sub_ff     <= sub_in;
      a_neg_ff   <= a_neg_in;
      c_neg_ff   <= c_neg_in;
      a_mag_ff   <= a_mag_in;
      c_mag_ff   <= c_mag_in;
      b_ff       <= b_in;
      d_ff       <= d_in;
      prod_ff    <= prod_in;
      p1_ff      <= p1_in;
      num_ff     <= num_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      den_ff     <= den_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
   end

   // Divider step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Status back to the controller.
   assign status.num_zero  = (num_ff == '0);
   assign status.both_even = !u_ff[0] && !v_ff[0];
   assign status.u_zero    = (u_ff == '0);
   assign status.div_last  = (cnt_ff == CW'(MW - 1));

   assign result_num = out_num_ff;
   assign result_den = out_den_ff;

   `ASSERT_IMPLIES(a_gcd_has_odd_value, clock, reset, cmd.gcd_en, u_ff[0] || v_ff[0], "gcd step with both values even")
   `ASSERT_IMPLIES(a_divisor_nonzero, clock, reset, cmd.div_start || cmd.div_step, v_ff != '0, "division by a zero gcd")

endmodule

// ===== src/rasr_ctrl.sv =====
// Controller: sequences one beat through multiply, gcd and divide steps.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rasr_ctrl
   import rasr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output rasr_cmd_type    cmd,
   input  rasr_status_type status
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MUL_AD  = 4'd1;
   localparam logic [3:0] S_MUL_CB  = 4'd2;
   localparam logic [3:0] S_MUL_BD  = 4'd3;
   localparam logic [3:0] S_NORM    = 4'd4;
   localparam logic [3:0] S_TWOS    = 4'd5;
   localparam logic [3:0] S_GCD     = 4'd6;
   localparam logic [3:0] S_DIV_NUM = 4'd7;
   localparam logic [3:0] S_DIV_DEN = 4'd8;
   localparam logic [3:0] S_FIN     = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_AD;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MUL_AD;
            end
         end
         S_MUL_AD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AD;
            state_in    = S_MUL_CB;
         end
         S_MUL_CB: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CB;
            cmd.p1_en   = 1'b1;
            state_in    = S_MUL_BD;
         end
         S_MUL_BD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_BD;
            cmd.num_en  = 1'b1;
            state_in    = S_NORM;
         end
         S_NORM: begin
            cmd.norm_en = 1'b1;
            state_in    = status.num_zero ? S_FIN : S_TWOS;
         end
         S_TWOS: begin
            if (status.both_even) begin
               cmd.twos_en = 1'b1;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (status.u_zero) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV_NUM;
            end else begin
               cmd.gcd_en = 1'b1;
            end
         end
         S_DIV_NUM: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               // Store the numerator quotient and start on the denominator.
               cmd.div_wr_num = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_den    = 1'b1;
               state_in       = S_DIV_DEN;
            end
         end
         S_DIV_DEN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               cmd.div_wr_den = 1'b1;
               state_in       = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result beat valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEXT(a_fin_delivers, clock, reset, cmd.out_load, rsp_tvalid && (state_ff == S_IDLE), "result not presented after output load")
   `ASSERT_NEXT(a_zero_skips_gcd, clock, reset, (state_ff == S_NORM) && status.num_zero, state_ff == S_FIN, "zero numerator did not go straight to output")

endmodule
